/* rtl/cfbp_pkg.sv */
// Package for the camera frame byte parser.
// Holds the register reset values, register indexes, parse phase codes and the result type.
// No dependencies.
package cfbp_pkg;

    localparam int FRAME_MAX = 10;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int CNT_W   = 16;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int RECENT_N  = 5;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER    = 2'd2;

    // Register reset values.
    localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'h2C;
    localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'h12;
    localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'h5B;

    // Parse phases.
    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HEADER2 = 2'd1;
    localparam logic [PHASE_W-1:0] PH_COLLECT = 2'd2;
    localparam logic [PHASE_W-1:0] PH_CHECK   = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_SAT  = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(FRAME_MAX);

    typedef struct packed {
        logic              frame_ready;
        logic              bad_tail;
        logic [BYTE_W-1:0] digit_value;
        logic [BYTE_W-1:0] side_code;
        logic [BYTE_W-1:0] found_flag;
        logic [BYTE_W-1:0] task_code;
        logic [CNT_W-1:0]  frames_received;
    } t_result;

endpackage

/* rtl/camera_frame_byte_parser.sv */
// Top level of the camera frame byte parser: header/tail framing of a received byte stream.
// Depends on cfbp_pkg for constants and the result type.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_rx_byte) carries one received byte per
//   transaction. Every accepted byte produces exactly one result transaction on the
//   output channel (o_out_valid, i_out_stall and the seven field ports).
//   The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   the first header, second header and end marker registers; index 3 is ignored.
//   The result of an accepted byte is registered in the output register, or in the skid
//   register while the output is held. Throughput is one byte per cycle while o_in_stall
//   is low, set by the single parse stage that updates the frame state and the result.
//   When the receiver stalls, the result waits in the output register and one more
//   result is caught in a skid register; only when the skid register is full does the
//   block raise o_in_stall, and it drops it as soon as the output moves again.
//   Synchronous reset (i_rst_n low) returns the registers to their reset values, clears
//   the published fields and frame counter, empties the output stages and puts the
//   parser back to waiting for the first header.
module camera_frame_byte_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_frame_ready,
    output logic        o_bad_tail,
    output logic [7:0]  o_digit_value,
    output logic [7:0]  o_side_code,
    output logic [7:0]  o_found_flag,
    output logic [7:0]  o_task_code,
    output logic [15:0] o_frames_received,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Configuration registers.
    logic [cfbp_pkg::BYTE_W-1:0] r_first_header;
    logic [cfbp_pkg::BYTE_W-1:0] r_second_header;
    logic [cfbp_pkg::BYTE_W-1:0] r_end_marker;

    // Frame state.
    logic [cfbp_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [cfbp_pkg::COUNT_W-1:0] r_count, n_count;
    logic [cfbp_pkg::BYTE_W-1:0]  r_recent [cfbp_pkg::RECENT_N];
    logic [cfbp_pkg::BYTE_W-1:0]  n_recent [cfbp_pkg::RECENT_N];
    logic [cfbp_pkg::BYTE_W-1:0]  r_pub [4];
    logic [cfbp_pkg::BYTE_W-1:0]  n_pub [4];
    logic [cfbp_pkg::CNT_W-1:0]   r_frames, n_frames;

    // Output register and skid register.
    logic                r_out_valid, r_skid_valid;
    cfbp_pkg::t_result   r_out, r_skid, n_result;

    logic in_accept;
    logic out_take;
    logic n_ready;
    logic n_bad;
    logic [cfbp_pkg::COUNT_W-1:0] count_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;

    // Configuration writes; an unknown index is simply dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_header  <= cfbp_pkg::FIRST_HEADER_RST;
            r_second_header <= cfbp_pkg::SECOND_HEADER_RST;
            r_end_marker    <= cfbp_pkg::END_MARKER_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cfbp_pkg::REG_FIRST_HEADER:  r_first_header  <= i_cfg_data;
                cfbp_pkg::REG_SECOND_HEADER: r_second_header <= i_cfg_data;
                cfbp_pkg::REG_END_MARKER:    r_end_marker    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The byte count saturates; in practice it never passes the frame limit.
    assign count_inc = (r_count == cfbp_pkg::COUNT_SAT) ? r_count : r_count + 1'b1;

    // Parse step for one byte.
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_recent = r_recent;
        n_pub    = r_pub;
        n_frames = r_frames;
        n_ready  = 1'b0;
        n_bad    = 1'b0;
        case (r_phase)
            cfbp_pkg::PH_IDLE: begin
                // A frame starts from a cleared history holding only the first header.
                if (i_rx_byte == r_first_header) begin
                    n_recent[0] = i_rx_byte;
                    for (int k = 1; k < cfbp_pkg::RECENT_N; k++) begin
                        n_recent[k] = '0;
                    end
                    n_count = cfbp_pkg::COUNT_W'(1);
                    n_phase = cfbp_pkg::PH_HEADER2;
                end
            end
            cfbp_pkg::PH_HEADER2: begin
                if (i_rx_byte == r_second_header) begin
                    n_recent[0] = i_rx_byte;
                    for (int k = 1; k < cfbp_pkg::RECENT_N; k++) begin
                        n_recent[k] = r_recent[k-1];
                    end
                    n_count = count_inc;
                    n_phase = cfbp_pkg::PH_COLLECT;
                end else begin
                    // Wrong second header: back to idle, the byte is not re-examined.
                    for (int k = 0; k < cfbp_pkg::RECENT_N; k++) begin
                        n_recent[k] = '0;
                    end
                    n_count = '0;
                    n_phase = cfbp_pkg::PH_IDLE;
                end
            end
            cfbp_pkg::PH_COLLECT: begin
                n_recent[0] = i_rx_byte;
                for (int k = 1; k < cfbp_pkg::RECENT_N; k++) begin
                    n_recent[k] = r_recent[k-1];
                end
                n_count = count_inc;
                if (count_inc >= cfbp_pkg::COUNT_FULL || i_rx_byte == r_end_marker) begin
                    // The four bytes before the closing byte, oldest first.
                    n_pub[0] = r_recent[3];
                    n_pub[1] = r_recent[2];
                    n_pub[2] = r_recent[1];
                    n_pub[3] = r_recent[0];
                    n_frames = r_frames + 1'b1;
                    n_phase  = cfbp_pkg::PH_CHECK;
                    n_ready  = 1'b1;
                end
            end
            default: begin
                // Check byte: its value is ignored, only the stored tail is judged.
                n_bad = (r_recent[0] != r_end_marker);
                for (int k = 0; k < cfbp_pkg::RECENT_N; k++) begin
                    n_recent[k] = '0;
                end
                n_count = '0;
                n_phase = cfbp_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        n_result.frame_ready     = n_ready;
        n_result.bad_tail        = n_bad;
        n_result.digit_value     = n_pub[0];
        n_result.side_code       = n_pub[1];
        n_result.found_flag      = n_pub[2];
        n_result.task_code       = n_pub[3];
        n_result.frames_received = n_frames;
    end

    // State update on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= cfbp_pkg::PH_IDLE;
            r_count  <= '0;
            r_frames <= '0;
            for (int k = 0; k < cfbp_pkg::RECENT_N; k++) begin
                r_recent[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_pub[k] <= '0;
            end
        end else if (in_accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_frames <= n_frames;
            r_recent <= n_recent;
            r_pub    <= n_pub;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                r_out_valid  <= r_skid_valid || in_accept;
                r_skid_valid <= 1'b0;
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (in_accept && r_out_valid && !out_take) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_ready     = r_out.frame_ready;
    assign o_bad_tail        = r_out.bad_tail;
    assign o_digit_value     = r_out.digit_value;
    assign o_side_code       = r_out.side_code;
    assign o_found_flag      = r_out.found_flag;
    assign o_task_code       = r_out.task_code;
    assign o_frames_received = r_out.frames_received;

    // The skid register only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register valid while output register empty");

    // A result cannot both close a frame and judge a tail.
    a_ready_bad_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.frame_ready && r_out.bad_tail))
        else $error("frame_ready and bad_tail in one result");

    // The check byte always returns the parser to a clean idle state.
    a_check_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == cfbp_pkg::PH_CHECK)
        |=> (r_phase == cfbp_pkg::PH_IDLE && r_count == '0))
        else $error("parser not idle after check byte");

    // While collecting, every byte is stored.
    a_collect_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == cfbp_pkg::PH_COLLECT)
        |=> (r_count == cfbp_pkg::COUNT_W'($past(r_count) + 1'b1)))
        else $error("byte count did not advance while collecting");

    // The frame counter moves only when a frame is published.
    a_frames_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !n_ready) |=> $stable(r_frames))
        else $error("frame counter changed without a published frame");

endmodule

/* test/tb.sv */
// Self-checking testbench for camera_frame_byte_parser: header/tail byte framing.
// Holds its own frame parser model and compares every result transaction with it.
// Depends on cfbp_pkg and the camera_frame_byte_parser RTL.
`timescale 1ns / 100ps

module tb;

    // Run shape. The random part spreads its bytes evenly over the register settings.
    localparam int N_SETTINGS        = 6;
    localparam int ITEMS_PER_SETTING = 267;
    localparam int DIR_N             = 29;
    localparam int CYCLE_LIMIT       = 200000;

    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [cfbp_pkg::CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;

    // One directed row: the byte to send and, where it is obvious, the result it must give.
    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        logic        rdy;
        logic        bad;
        logic [7:0]  f0;
        logic [7:0]  f1;
        logic [7:0]  f2;
        logic [7:0]  f3;
        logic [15:0] cnt;
    } t_dir_row;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic        frame_ready;
    logic        bad_tail;
    logic [7:0]  digit_value;
    logic [7:0]  side_code;
    logic [7:0]  found_flag;
    logic [7:0]  task_code;
    logic [15:0] frames_received;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Idling rates, in percent, for the sender gaps and the receiver stalls.
    int send_pct;
    int recv_pct;

    // Bookkeeping for the summary and the verdict.
    int          n_errors;
    int          n_bytes_sent;
    int          n_reports_seen;
    int          n_frames_seen;
    int          n_bad_tails_seen;
    int unsigned n_cycles;

    // Model of the parser: its copy of the registers and of the frame state.
    logic [7:0]                   hdr_a;
    logic [7:0]                   hdr_b;
    logic [7:0]                   end_mark;
    logic [cfbp_pkg::PHASE_W-1:0] ph;
    logic [3:0]                   frame_len;
    logic [7:0]                   tail_bytes [cfbp_pkg::RECENT_N];
    logic [7:0]                   shown [4];
    logic [15:0]                  frame_total;

    // Results the block still owes, oldest first.
    cfbp_pkg::t_result reports_due [$];

    // Directed table. Typed rows carry a result that can be read straight off the framing
    // rules; the others are left to the model. With the reset registers (0x2C, 0x12, 0x5B)
    // it walks through a wrong first header, a wrong second header that happens to equal
    // the first header (it must not restart the frame), a frame whose end marker follows
    // the headers at once, a frame closed by its end marker at full length, and a frame
    // cut off at full length whose check byte then reports a bad tail.
    t_dir_row dir_rows [DIR_N] = '{
        '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h2C, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h2C, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h2C, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h12, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h5B, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h2C, 8'h12, 16'd1},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h2C, 8'h12, 16'd1},
        '{8'h2C, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h12, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'hA5, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h5A, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h5B, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h2C, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h12, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h11, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h22, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h33, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h44, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h66, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h77, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},
        '{8'h88, 1'b1, 1'b1, 1'b0, 8'h44, 8'h55, 8'h66, 8'h77, 16'd3},
        '{8'h5B, 1'b1, 1'b0, 1'b1, 8'h44, 8'h55, 8'h66, 8'h77, 16'd3}
    };

    // Register settings for the random part, one per stretch: the reset values, the
    // extremes, and one random setting (row 3 is filled in at run time).
    logic [7:0] setting_vals [N_SETTINGS][3] = '{
        '{8'h2C, 8'h12, 8'h5B},
        '{8'h00, 8'hFF, 8'h00},
        '{8'hFF, 8'h00, 8'hFF},
        '{8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'hFF}
    };

    camera_frame_byte_parser i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_rx_byte         (rx_byte),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_frame_ready     (frame_ready),
        .o_bad_tail        (bad_tail),
        .o_digit_value     (digit_value),
        .o_side_code       (side_code),
        .o_found_flag      (found_flag),
        .o_task_code       (task_code),
        .o_frames_received (frames_received),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    // 100 MHz clock.
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Drops the frame being assembled and goes back to looking for the first header.
    function automatic void clear_frame();
        ph        = cfbp_pkg::PH_IDLE;
        frame_len = '0;
        for (int i = 0; i < cfbp_pkg::RECENT_N; i++) tail_bytes[i] = '0;
    endfunction

    // Shifts a byte into the history, newest at index 0; the length saturates at 15.
    function automatic void keep_byte(input logic [7:0] b);
        for (int i = cfbp_pkg::RECENT_N - 1; i > 0; i--) tail_bytes[i] = tail_bytes[i-1];
        tail_bytes[0] = b;
        if (frame_len != cfbp_pkg::COUNT_SAT) frame_len++;
    endfunction

    // Advances the model by one received byte and returns the result that byte must give.
    function automatic cfbp_pkg::t_result parse_byte(input logic [7:0] b);
        cfbp_pkg::t_result r;
        r = '0;
        case (ph)
            cfbp_pkg::PH_IDLE: begin
                if (b == hdr_a) begin
                    clear_frame();
                    keep_byte(b);
                    ph = cfbp_pkg::PH_HEADER2;
                end
            end
            cfbp_pkg::PH_HEADER2: begin
                // A wrong second header just drops the frame; it never starts a new one.
                if (b == hdr_b) begin
                    keep_byte(b);
                    ph = cfbp_pkg::PH_COLLECT;
                end else begin
                    clear_frame();
                end
            end
            cfbp_pkg::PH_COLLECT: begin
                keep_byte(b);
                // The frame closes on its end marker or when it reaches full length; the
                // four bytes before the closing one become the published fields.
                if (frame_len >= cfbp_pkg::FRAME_MAX || b == end_mark) begin
                    for (int i = 0; i < 4; i++) shown[i] = tail_bytes[4-i];
                    frame_total   = frame_total + 16'd1;
                    ph            = cfbp_pkg::PH_CHECK;
                    r.frame_ready = 1'b1;
                end
            end
            default: begin
                // The check byte's own value does not matter, only how the frame ended.
                r.bad_tail = (tail_bytes[0] != end_mark);
                clear_frame();
            end
        endcase
        r.digit_value     = shown[0];
        r.side_code       = shown[1];
        r.found_flag      = shown[2];
        r.task_code       = shown[3];
        r.frames_received = frame_total;
        return r;
    endfunction

    // Sends one byte as an input transaction, after a random number of idle cycles.
    // Once the byte is taken, the model runs and its result joins the queue of results due.
    // A typed result, where given, is queued instead of the model's.
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input cfbp_pkg::t_result typed_val);
        cfbp_pkg::t_result predicted;
        while ($urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        predicted = parse_byte(b);
        reports_due.push_back(typed ? typed_val : predicted);
        n_bytes_sent++;
    endtask

    // One write transaction on the configuration port; the model takes the value along.
    task automatic write_reg(input logic [cfbp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            cfbp_pkg::REG_FIRST_HEADER:  hdr_a    = val;
            cfbp_pkg::REG_SECOND_HEADER: hdr_b    = val;
            cfbp_pkg::REG_END_MARKER:    end_mark = val;
            default: ;
        endcase
    endtask

    // Any byte except the current end marker, for payloads that must not close early.
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == end_mark);
        return b;
    endfunction

    // One random burst of bytes. Most bursts are well-formed frames with random payloads,
    // so that the parser spends most of its time past the headers; the rest are frames
    // that run to full length, frames broken at the second header, and plain noise.
    task automatic emit_random_burst();
        int kind;
        int plen;
        kind = $urandom_range(99);
        if (kind < 85) begin
            send_byte(hdr_a, 1'b0, '0);
            send_byte(hdr_b, 1'b0, '0);
            // Up to seven payload bytes keep the end marker within the length limit; the
            // longer frames are cut off at full length instead.
            plen = (kind < 70) ? $urandom_range(0, 7) : cfbp_pkg::FRAME_MAX - 2;
            for (int i = 0; i < plen; i++) send_byte(payload_byte(), 1'b0, '0);
            if (kind < 70) send_byte(end_mark, 1'b0, '0);
            // The check byte is sometimes the end marker itself, to show it is ignored.
            send_byte(($urandom_range(3) == 0) ? end_mark : 8'($urandom), 1'b0, '0);
        end else if (kind < 93) begin
            send_byte(hdr_a, 1'b0, '0);
            if ($urandom_range(1) == 0) begin
                send_byte(hdr_a, 1'b0, '0);
            end else begin
                send_byte(8'(hdr_b + 8'($urandom_range(1, 255))), 1'b0, '0);
            end
        end else begin
            plen = $urandom_range(1, 3);
            for (int i = 0; i < plen; i++) send_byte(8'($urandom), 1'b0, '0);
        end
    endtask

    // Compares one field of a result transaction and reports a difference.
    task automatic report_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want_v, got_v);
            n_errors++;
        end
    endtask

    // Receiver: stalls at random at the current rate, one decision per cycle.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_pct);
    end

    // Result checker. Every result transaction is matched against the oldest result due.
    // Signals are sampled at the edge, before the block's own updates take effect.
    always @(posedge clk) begin : check_results
        cfbp_pkg::t_result got;
        cfbp_pkg::t_result want;
        if (rst_n && out_valid && !out_stall) begin
            got = {frame_ready, bad_tail, digit_value, side_code, found_flag, task_code,
                   frames_received};
            n_reports_seen++;
            if (got.frame_ready) n_frames_seen++;
            if (got.bad_tail) n_bad_tails_seen++;
            if (reports_due.size() == 0) begin
                $display("%0t: result with nothing due, expected none, actual 0x%0h",
                         $time, got);
                n_errors++;
            end else begin
                want = reports_due.pop_front();
                report_field("frame_ready", want.frame_ready, got.frame_ready);
                report_field("bad_tail", want.bad_tail, got.bad_tail);
                report_field("digit_value", want.digit_value, got.digit_value);
                report_field("side_code", want.side_code, got.side_code);
                report_field("found_flag", want.found_flag, got.found_flag);
                report_field("task_code", want.task_code, got.task_code);
                report_field("frames_received", want.frames_received, got.frames_received);
            end
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, n_cycles, reports_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random stretches under each register
    // setting and idling pattern, then drain and verdict.
    initial begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        rx_byte          = '0;
        out_stall        = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        send_pct         = 36;
        recv_pct         = 74;
        n_errors         = 0;
        n_bytes_sent     = 0;
        n_reports_seen   = 0;
        n_frames_seen    = 0;
        n_bad_tails_seen = 0;
        n_cycles         = 0;
        hdr_a            = cfbp_pkg::FIRST_HEADER_RST;
        hdr_b            = cfbp_pkg::SECOND_HEADER_RST;
        end_mark         = cfbp_pkg::END_MARKER_RST;
        frame_total      = '0;
        for (int i = 0; i < 4; i++) shown[i] = '0;
        clear_frame();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the registers at their reset values.
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].rx, dir_rows[i].typed,
                      {dir_rows[i].rdy, dir_rows[i].bad, dir_rows[i].f0, dir_rows[i].f1,
                       dir_rows[i].f2, dir_rows[i].f3, dir_rows[i].cnt});
        end
        in_valid <= 1'b0;

        setting_vals[3] = '{8'($urandom), 8'($urandom), 8'($urandom)};
        for (int p = 0; p < N_SETTINGS; p++) begin : random_stretch
            int stretch_start;
            // The first two stretches stall the receiver side most, the next two idle the sender
            // side most, and the last two run at full rate in both directions.
            send_pct = (p < 2) ? 36 : (p < 4) ? 74 : 0;
            recv_pct = (p < 2) ? 74 : (p < 4) ? 36 : 0;

            // Registers change only when no result is outstanding.
            while (reports_due.size() != 0) @(posedge clk);
            write_reg(cfbp_pkg::REG_FIRST_HEADER, setting_vals[p][0]);
            write_reg(cfbp_pkg::REG_SECOND_HEADER, setting_vals[p][1]);
            write_reg(cfbp_pkg::REG_END_MARKER, setting_vals[p][2]);
            write_reg(REG_UNUSED_IDX, 8'($urandom));

            stretch_start = n_bytes_sent;
            while (n_bytes_sent - stretch_start < ITEMS_PER_SETTING) emit_random_burst();
            in_valid <= 1'b0;
        end

        // Drain, then wait for a stray late result to show up.
        while (reports_due.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Summary: %0d bytes sent, %0d results checked, %0d frames published,",
                 n_bytes_sent, n_reports_seen, n_frames_seen);
        $display("Summary: %0d bad tails, %0d register settings, three idling patterns, %0d mismatches",
                 n_bad_tails_seen, N_SETTINGS, n_errors);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/cfbp_pkg.sv
rtl/camera_frame_byte_parser.sv
test/tb.sv
